@@ rtl/donchian_breakout_atr_core_assert.svh @@
// Assertion macros used by the block's top-level RTL file.
`ifndef DONCHIAN_BREAKOUT_ATR_CORE_ASSERT_SVH
`define DONCHIAN_BREAKOUT_ATR_CORE_ASSERT_SVH

// Antecedent holds in this cycle, consequent holds in the same cycle.
`define DBATR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds in this cycle, consequent holds in the next one.
`define DBATR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dbatr_pkg.sv @@
`default_nettype none

package dbatr_pkg;

	// Parameter defaults
	localparam int MAX_WINDOW_DEF = 64;
	localparam int ATR_PERIOD_DEF = 14;
	localparam int PRICE_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Fixed field and state widths
	localparam int ATR_BITS   = 48;
	localparam int DIV_W      = 64;
	localparam int WIN_BITS   = 6;
	localparam int COOL_BITS  = 4;
	localparam int CNT_BITS   = 7;
	localparam int SINCE_BITS = 5;
	localparam int SIG_BITS   = 2;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [CNT_BITS-1:0]   COUNT_MAX = 7'd127;
	localparam logic [SINCE_BITS-1:0] SINCE_MAX = 5'd31;

	localparam logic [WIN_BITS-1:0]  WINDOW_RESET   = 6'd20;
	localparam logic [COOL_BITS-1:0] COOLDOWN_RESET = 4'd1;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COOLDOWN   = 1'b1;

	// Signal codes
	localparam logic [SIG_BITS-1:0] SIG_NONE  = 2'b00;
	localparam logic [SIG_BITS-1:0] SIG_LONG  = 2'b01;
	localparam logic [SIG_BITS-1:0] SIG_SHORT = 2'b11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TR,
		ST_LOAD,
		ST_RUN,
		ST_DONE
	} dbatr_state_t;

	// Control broadcast to every history cell
	typedef struct packed {
		logic                shift;
		logic                start;
		logic [WIN_BITS-1:0] win;
	} dbatr_cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/dbatr_div.sv @@
`default_nettype none

module dbatr_div #(
	parameter int DIVISOR = dbatr_pkg::ATR_PERIOD_DEF,
	parameter int W       = dbatr_pkg::DIV_W
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	output logic              busy,
	output logic              done,
	output logic [W-1:0]      quotient
);
	localparam int DIG   = 8;
	localparam int STEPS = W / DIG;
	localparam int RB    = $clog2(DIVISOR);
	localparam int TW    = RB + DIG;
	localparam int SH    = TW + RB;
	localparam int PW    = 2*TW + 2;
	localparam int CB    = $clog2(STEPS + 1);
	// Rounded-up reciprocal, exact for every TW-bit trial value
	localparam longint RECIP =
		((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);

	logic [W-1:0]   dvd_q;
	logic [RB-1:0]  rem_q;
	logic [CB-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [TW-1:0]  trial;
	logic [PW-1:0]  prod;
	logic [DIG-1:0] qdig;
	logic [TW-1:0]  rem_full;

	// One quotient byte per cycle, top byte first; quotient bytes enter at the bottom
	assign trial    = {rem_q, dvd_q[W-1 -: DIG]};
	assign prod     = PW'(trial) * PW'(RECIP);
	assign qdig     = prod[SH +: DIG];
	assign rem_full = trial - TW'(qdig) * TW'(DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CB'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CB'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-DIG-1:0], qdig};
			rem_q <= rem_full[RB-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

@@ rtl/dbatr_cell.sv @@
`default_nettype none

module dbatr_cell #(
	parameter int INDEX      = 0,
	parameter int PRICE_BITS = dbatr_pkg::PRICE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dbatr_pkg::dbatr_cell_ctl_t ctl,
	input  wire logic [PRICE_BITS-1:0]     hist_hi_in,
	input  wire logic [PRICE_BITS-1:0]     hist_lo_in,
	output logic [PRICE_BITS-1:0]          hist_hi,
	output logic [PRICE_BITS-1:0]          hist_lo,
	input  wire logic                      tok_vld_in,
	input  wire logic [PRICE_BITS-1:0]     tok_hi_in,
	input  wire logic [PRICE_BITS-1:0]     tok_lo_in,
	output logic                           tok_vld,
	output logic [PRICE_BITS-1:0]          tok_hi,
	output logic [PRICE_BITS-1:0]          tok_lo
);
	import dbatr_pkg::*;

	logic [PRICE_BITS-1:0] hi_q;
	logic [PRICE_BITS-1:0] lo_q;
	logic                  tok_vld_q;
	logic [PRICE_BITS-1:0] tok_hi_q;
	logic [PRICE_BITS-1:0] tok_lo_q;
	logic                  in_win;

	// Cell INDEX holds the bar INDEX+1 bars back; the channel spans cells 1..win
	assign in_win = (INDEX >= 1) && (INDEX <= int'(ctl.win));

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			hi_q <= hist_hi_in;
			lo_q <= hist_lo_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_vld_in;
		end
	end

	// Fold this cell's bar into the running max/min and pass it on
	always_ff @(posedge clk) begin
		tok_hi_q <= (in_win && hi_q > tok_hi_in) ? hi_q : tok_hi_in;
		tok_lo_q <= (in_win && lo_q < tok_lo_in) ? lo_q : tok_lo_in;
	end

	assign hist_hi = hi_q;
	assign hist_lo = lo_q;
	assign tok_vld = tok_vld_q;
	assign tok_hi  = tok_hi_q;
	assign tok_lo  = tok_lo_q;

endmodule

`default_nettype wire

@@ rtl/donchian_breakout_atr_core.sv @@
// Donchian channel breakout with a Wilder average true range.
//
// Input stream s_*: one price bar per transfer, s_tdata = {close, low, high}.
// Output stream m_*: one result per bar, in bar order.
// Config channel cfg_*: cfg_index 0 writes window_len, 1 writes cooldown_bars;
// always ready, write only while no bar is in flight.
//
// One bar is in flight at a time. After the input transfer the true range
// is registered in ST_TR, then ST_LOAD forms the ATR dividend and starts the
// history row and the divider, which run side by side: the running max/min
// token walks MAX_WINDOW cells one per cycle, the divide by ATR_PERIOD
// retires one quotient byte per cycle by reciprocal multiplication (8 steps).
// Once both are done, the result is written to the output register, and the
// next bar can be taken the cycle after that.
//
// Reset clears ATR, counters, cooldown and the output valid, and sets the
// registers to window_len 20, cooldown_bars 1. If the receiver stalls, the
// result waits in the output register; the next bar is still accepted and
// computed, and its result holds until the output register is free.
`default_nettype none

module donchian_breakout_atr_core #(
	parameter int MAX_WINDOW = dbatr_pkg::MAX_WINDOW_DEF,
	parameter int ATR_PERIOD = dbatr_pkg::ATR_PERIOD_DEF,
	parameter int PRICE_BITS = dbatr_pkg::PRICE_BITS_DEF,
	parameter int FRAC_BITS  = dbatr_pkg::FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// bar_high, bar_low, bar_close
	input  wire logic [((3*PRICE_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// signal, atr_out, chan_high, chan_low
	output logic [((dbatr_pkg::SIG_BITS+dbatr_pkg::ATR_BITS+2*PRICE_BITS+7)/8)*8-1:0] m_tdata,
	// ready_res
	output logic      m_tuser,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [dbatr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [dbatr_pkg::WIN_BITS-1:0]     cfg_data
);
	import dbatr_pkg::*;

	`include "donchian_breakout_atr_core_assert.svh"

	localparam int OUT_W    = ((SIG_BITS+ATR_BITS+2*PRICE_BITS+7)/8)*8;
	localparam int RSUM_BITS = PRICE_BITS + $clog2(ATR_PERIOD);
	localparam int MUL_BITS  = ATR_BITS + $clog2(ATR_PERIOD);

	dbatr_state_t state_q, state_d;

	// Configuration
	logic [WIN_BITS-1:0]  win_len_q;
	logic [COOL_BITS-1:0] cool_bars_q;
	logic [WIN_BITS-1:0]  win_eff;

	// Bar under work
	logic [PRICE_BITS-1:0] bar_high_q, bar_low_q, bar_close_q;
	logic [PRICE_BITS-1:0] tr_q;

	// Persistent state
	logic [PRICE_BITS-1:0] prev_close_q;
	logic [ATR_BITS-1:0]   atr_q;
	logic [RSUM_BITS-1:0]  range_sum_q;
	logic [CNT_BITS-1:0]   bar_count_q;
	logic [SINCE_BITS-1:0] since_q;
	logic                  has_sig_q;

	// Completion tracking
	logic                  chan_done_q, div_done_q;
	logic [PRICE_BITS-1:0] chi_q, clo_q;

	// Output register
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;
	logic                  m_tuser_q;

	dbatr_cell_ctl_t cell_ctl;
	logic            out_load;
	logic            out_free;
	logic            accept;

	// True range
	logic [PRICE_BITS-1:0] tr_hl, tr_hc, tr_lc, tr_m, tr_d;

	// ATR dividend
	logic [RSUM_BITS-1:0] rs_new;
	logic [MUL_BITS-1:0]  atr_mul;
	logic [DIV_W-1:0]     dividend;
	logic                 div_busy, div_done;
	logic [DIV_W-1:0]     quotient;

	// Result
	logic [ATR_BITS-1:0]   atr_new;
	logic                  chan_ok, ready_res, cool;
	logic [SINCE_BITS-1:0] since_inc;
	logic [SIG_BITS-1:0]   sig;
	logic [PRICE_BITS-1:0] chi_out, clo_out;

	// History row
	logic [PRICE_BITS-1:0] hist_hi [MAX_WINDOW];
	logic [PRICE_BITS-1:0] hist_lo [MAX_WINDOW];
	logic                  tok_vld [MAX_WINDOW];
	logic [PRICE_BITS-1:0] tok_hi  [MAX_WINDOW];
	logic [PRICE_BITS-1:0] tok_lo  [MAX_WINDOW];

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q   <= WINDOW_RESET;
			cool_bars_q <= COOLDOWN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WINDOW_LEN: win_len_q   <= cfg_data[WIN_BITS-1:0];
				CFG_COOLDOWN:   cool_bars_q <= cfg_data[COOL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Zero acts as one, clamp to what the row holds
	always_comb begin
		win_eff = (win_len_q == '0) ? WIN_BITS'(1) : win_len_q;
		if (int'(win_eff) > MAX_WINDOW - 1) begin
			win_eff = WIN_BITS'(MAX_WINDOW - 1);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		s_tready       = 1'b0;
		cell_ctl.start = 1'b0;
		cell_ctl.shift = 1'b0;
		cell_ctl.win   = win_eff;
		out_load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_TR;
				end
			end
			ST_TR: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cell_ctl.start = 1'b1;
				state_d        = ST_RUN;
			end
			ST_RUN: begin
				if (chan_done_q && div_done_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load       = 1'b1;
					cell_ctl.shift = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bar_high_q  <= s_tdata[PRICE_BITS-1:0];
			bar_low_q   <= s_tdata[2*PRICE_BITS-1:PRICE_BITS];
			bar_close_q <= s_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
		end
	end

	// True range: max of high-low (zero if inverted), |high-prev|, |low-prev|
	always_comb begin
		tr_hl = (bar_high_q >= bar_low_q) ? bar_high_q - bar_low_q : '0;
		tr_hc = (bar_high_q >= prev_close_q) ? bar_high_q - prev_close_q
			: prev_close_q - bar_high_q;
		tr_lc = (bar_low_q >= prev_close_q) ? bar_low_q - prev_close_q
			: prev_close_q - bar_low_q;
		tr_m  = (tr_hc > tr_hl) ? tr_hc : tr_hl;
		tr_d  = (tr_lc > tr_m) ? tr_lc : tr_m;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TR) begin
			tr_q <= tr_d;
		end
	end

	// Seed mean on the ATR_PERIOD-th range, Wilder recursion afterwards
	assign rs_new  = range_sum_q + RSUM_BITS'(tr_q);
	assign atr_mul = MUL_BITS'(atr_q) * MUL_BITS'(ATR_PERIOD - 1);

	always_comb begin
		if (bar_count_q == CNT_BITS'(ATR_PERIOD)) begin
			dividend = DIV_W'(rs_new) << FRAC_BITS;
		end else begin
			dividend = DIV_W'(atr_mul) + (DIV_W'(tr_q) << FRAC_BITS);
		end
	end

	dbatr_div #(
		.DIVISOR (ATR_PERIOD),
		.W       (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cell_ctl.start),
		.dividend (dividend),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	// History row with the channel max/min token walking through it
	for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
		logic [PRICE_BITS-1:0] hi_in, lo_in, thi_in, tlo_in;
		logic                  tv_in;
		if (j == 0) begin : g_head
			assign hi_in  = bar_high_q;
			assign lo_in  = bar_low_q;
			assign tv_in  = cell_ctl.start;
			assign thi_in = '0;
			assign tlo_in = '1;
		end else begin : g_body
			assign hi_in  = hist_hi[j-1];
			assign lo_in  = hist_lo[j-1];
			assign tv_in  = tok_vld[j-1];
			assign thi_in = tok_hi[j-1];
			assign tlo_in = tok_lo[j-1];
		end
		dbatr_cell #(
			.INDEX      (j),
			.PRICE_BITS (PRICE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.hist_hi_in (hi_in),
			.hist_lo_in (lo_in),
			.hist_hi    (hist_hi[j]),
			.hist_lo    (hist_lo[j]),
			.tok_vld_in (tv_in),
			.tok_hi_in  (thi_in),
			.tok_lo_in  (tlo_in),
			.tok_vld    (tok_vld[j]),
			.tok_hi     (tok_hi[j]),
			.tok_lo     (tok_lo[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_done_q <= 1'b0;
			div_done_q  <= 1'b0;
		end else if (cell_ctl.start) begin
			chan_done_q <= 1'b0;
			div_done_q  <= 1'b0;
		end else begin
			if (tok_vld[MAX_WINDOW-1]) begin
				chan_done_q <= 1'b1;
			end
			if (div_done) begin
				div_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_vld[MAX_WINDOW-1]) begin
			chi_q <= tok_hi[MAX_WINDOW-1];
			clo_q <= tok_lo[MAX_WINDOW-1];
		end
	end

	// Result
	always_comb begin
		atr_new   = (bar_count_q >= CNT_BITS'(ATR_PERIOD)) ? quotient[ATR_BITS-1:0] : atr_q;
		chan_ok   = bar_count_q >= (CNT_BITS'(win_eff) + CNT_BITS'(1));
		ready_res = (bar_count_q >= CNT_BITS'(ATR_PERIOD + 1)) && (atr_new != '0);
		since_inc = (has_sig_q && since_q != SINCE_MAX) ? since_q + 1'b1 : since_q;
		cool      = has_sig_q && (since_inc <= SINCE_BITS'(cool_bars_q));
		chi_out   = chan_ok ? chi_q : '0;
		clo_out   = chan_ok ? clo_q : '0;
		sig       = SIG_NONE;
		if (ready_res && !cool && chan_ok) begin
			if (bar_close_q > chi_q) begin
				sig = SIG_LONG;
			end else if (bar_close_q < clo_q) begin
				sig = SIG_SHORT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_close_q <= '0;
			atr_q        <= '0;
			range_sum_q  <= '0;
			bar_count_q  <= '0;
			since_q      <= '0;
			has_sig_q    <= 1'b0;
		end else begin
			if (state_q == ST_LOAD && bar_count_q != '0
				&& bar_count_q <= CNT_BITS'(ATR_PERIOD)) begin
				range_sum_q <= rs_new;
			end
			if (out_load) begin
				atr_q        <= atr_new;
				prev_close_q <= bar_close_q;
				if (bar_count_q != COUNT_MAX) begin
					bar_count_q <= bar_count_q + 1'b1;
				end
				if (sig != SIG_NONE) begin
					has_sig_q <= 1'b1;
					since_q   <= '0;
				end else begin
					since_q <= since_inc;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= OUT_W'({clo_out, chi_out, atr_new, sig});
			m_tuser_q <= ready_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`DBATR_ASSERT_NOW(a_start_div_idle, cell_ctl.start, !div_busy,
		"divider started while busy")
	`DBATR_ASSERT_NOW(a_done_both, state_q == ST_DONE, chan_done_q && div_done_q,
		"result stage entered before channel and ATR finished")
	`DBATR_ASSERT_NOW(a_idle_no_token, state_q == ST_IDLE, !tok_vld[MAX_WINDOW-1],
		"channel token still in flight while idle")
	`DBATR_ASSERT_NEXT(a_hold_on_stall, state_q == ST_DONE && m_tvalid_q && !m_tready,
		state_q == ST_DONE, "result left done stage while output stalled")
	`DBATR_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_TR,
		"accepted bar did not start processing")

endmodule

`default_nettype wire

@@ tb/tb_donchian_breakout_atr_core.sv @@
`timescale 1ns / 100ps

module tb_donchian_breakout_atr_core;
	import dbatr_pkg::*;

	localparam int IN_W = ((3*PRICE_BITS_DEF+7)/8)*8;
	localparam int OUT_W = ((SIG_BITS+ATR_BITS+2*PRICE_BITS_DEF+7)/8)*8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 80;

	typedef struct packed {
		logic [SIG_BITS-1:0] sig;
		logic [ATR_BITS-1:0] atr;
		logic [31:0]         chi;
		logic [31:0]         clo;
		logic                rdy;
	} bar_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = CFG_WINDOW_LEN;
	logic [WIN_BITS-1:0] cfg_data = '0;

	donchian_breakout_atr_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted block state and registers
	logic [31:0] high_hist [MAX_WINDOW_DEF];
	logic [31:0] low_hist [MAX_WINDOW_DEF];
	logic [5:0] hist_wp = '0;
	logic [31:0] last_close = '0;
	logic [63:0] tr_sum = '0;
	logic [ATR_BITS-1:0] atr_val = '0;
	logic [CNT_BITS-1:0] bar_cnt = '0;
	logic [SINCE_BITS-1:0] since_sig = '0;
	logic signalled = 1'b0;
	logic [WIN_BITS-1:0] win_reg = WINDOW_RESET;
	logic [COOL_BITS-1:0] cool_reg = COOLDOWN_RESET;

	bar_result_t breakout_q[$];
	int err_cnt = 0;
	int result_cnt = 0;
	int cycles = 0;
	int rx_hold = 0;
	bit no_idle = 1'b0;
	longint level = 64'd2000000000;
	longint drift = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH: %s", what);
		err_cnt++;
	endtask

	function automatic logic [31:0] true_range(input logic [31:0] h, l, pc);
		logic [31:0] r, a, b;
		r = (h >= l) ? h - l : 32'd0;
		a = (h >= pc) ? h - pc : pc - h;
		b = (l >= pc) ? l - pc : pc - l;
		if (a > r) r = a;
		if (b > r) r = b;
		return r;
	endfunction

	// Advance the predicted state by one bar and queue its result
	task automatic predict_bar(input logic [31:0] h, l, c);
		logic [31:0] tr;
		logic [63:0] wide;
		logic [31:0] hi, lo;
		logic chan_ok, cool, rdy;
		logic [SIG_BITS-1:0] sig;
		bar_result_t res;
		int n, k, slot;
		n = (win_reg == 0) ? 1 : int'(win_reg);
		if (n > MAX_WINDOW_DEF - 1) n = MAX_WINDOW_DEF - 1;
		if (bar_cnt >= 1) begin
			tr = true_range(h, l, last_close);
			if (bar_cnt <= ATR_PERIOD_DEF) begin
				tr_sum = tr_sum + 64'(tr);
				if (bar_cnt == ATR_PERIOD_DEF)
					atr_val = ATR_BITS'((tr_sum << FRAC_BITS_DEF) / 64'(ATR_PERIOD_DEF));
			end else begin
				wide = 64'(atr_val) * 64'(ATR_PERIOD_DEF - 1) + (64'(tr) << FRAC_BITS_DEF);
				atr_val = ATR_BITS'(wide / 64'(ATR_PERIOD_DEF));
			end
		end
		// Channel spans bars i-2 down to i-1-n
		hi = '0;
		lo = '0;
		chan_ok = int'(bar_cnt) >= n + 1;
		if (chan_ok) begin
			for (k = 2; k <= n + 1; k++) begin
				slot = (int'(hist_wp) + MAX_WINDOW_DEF - k) % MAX_WINDOW_DEF;
				if (k == 2 || high_hist[slot] > hi) hi = high_hist[slot];
				if (k == 2 || low_hist[slot] < lo) lo = low_hist[slot];
			end
		end
		if (signalled && since_sig < SINCE_MAX) since_sig++;
		cool = signalled && (since_sig <= cool_reg);
		rdy = (int'(bar_cnt) >= ATR_PERIOD_DEF + 1) && (atr_val != 0);
		sig = SIG_NONE;
		if (rdy && !cool && chan_ok) begin
			if (c > hi) sig = SIG_LONG;
			else if (c < lo) sig = SIG_SHORT;
			if (sig != SIG_NONE) begin
				signalled = 1'b1;
				since_sig = '0;
			end
		end
		high_hist[hist_wp] = h;
		low_hist[hist_wp] = l;
		hist_wp = hist_wp + 6'd1;
		last_close = c;
		if (bar_cnt < COUNT_MAX) bar_cnt++;
		res = '{sig, atr_val, hi, lo, rdy};
		breakout_q = {breakout_q, res};
	endtask

	task automatic send_bar(input logic [31:0] h, l, c);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {c, l, h};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_bar(h, l, c);
		if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
	endtask

	// Hold the input side until every queued result has come back
	task automatic drain_bars();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (breakout_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [WIN_BITS-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_WINDOW_LEN) win_reg = val;
		else cool_reg = val[COOL_BITS-1:0];
		@(posedge clk);
	endtask

	task automatic apply_settings(input int win, input int cool);
		drain_bars();
		write_reg(CFG_WINDOW_LEN, WIN_BITS'(win));
		// upper data bits are don't-care for the cooldown register
		write_reg(CFG_COOLDOWN, {2'($urandom_range(0, 3)), COOL_BITS'(cool)});
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 2))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Mostly a drifting price walk with occasional closes outside the bar, plus random, extreme and inverted bars
	task automatic run_phase(input int win, input int cool, input int count);
		logic [31:0] h, l, c;
		int mode;
		apply_settings(win, cool);
		drift = longint'($urandom_range(0, 600)) - 300;
		repeat (count) begin
			mode = $urandom_range(0, 99);
			if (mode < 70) begin
				level = level + longint'($urandom_range(0, 4000)) - 2000 + drift;
				if (level < 64'd1000000) level = 64'd1000000;
				if (level > 64'd4293000000) level = 64'd4293000000;
				h = 32'(level + longint'($urandom_range(0, 1500)));
				l = 32'(level - longint'($urandom_range(0, 1500)));
				if ($urandom_range(0, 4) == 0)
					c = $urandom_range(0, 1) ? h + $urandom_range(1, 5000)
						: l - $urandom_range(1, 5000);
				else
					c = l + $urandom_range(0, h - l);
			end else if (mode < 85) begin
				h = $urandom;
				l = $urandom;
				c = $urandom;
			end else if (mode < 93) begin
				h = pick_extreme();
				l = pick_extreme();
				c = pick_extreme();
			end else begin
				h = 32'(level - longint'($urandom_range(1, 1500)));
				l = 32'(level + longint'($urandom_range(1, 1500)));
				c = 32'(level);
			end
			send_bar(h, l, c);
			if ($urandom_range(0, 39) == 0) drain_bars();
		end
	endtask

	// Flat zero bars: warm-up, channel not yet formed, ATR stuck at zero
	task automatic test_flat_warmup();
		repeat (16) send_bar(32'd0, 32'd0, 32'd0);
	endtask

	// Zero window, no cooldown: extremes, inverted bars, a short at close zero
	task automatic test_edge_bars();
		apply_settings(0, 0);
		send_bar(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		send_bar(32'd200, 32'd100, 32'd150);
		send_bar(32'd300, 32'hFFFF_FFFF, 32'd250);
		send_bar(32'd0, 32'd0, 32'd0);
		send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_bar(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_bar(32'h1234_5678, 32'h1234_5600, 32'h1234_5650);
	endtask

	task automatic test_window_extremes();
		run_phase(1, 0, 100);
		run_phase(63, 15, 100);
	endtask

	task automatic test_cooldown_range();
		run_phase(2, 15, 100);
		run_phase(5, 3, 100);
		run_phase(20, 1, 100);
	endtask

	task automatic test_random_settings();
		repeat (2) run_phase($urandom_range(0, 63), $urandom_range(0, 15), 100);
	endtask

	// Output side: after each transfer stall for a drawn number of cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tready && m_tvalid) begin
				rx_hold = no_idle ? 0 : $urandom_range(0, 17);
				if (rx_hold != 0) m_tready <= 1'b0;
			end else if (!m_tready) begin
				if (rx_hold > 0) rx_hold--;
				if (rx_hold == 0) m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		bar_result_t want;
		bar_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[1:0], m_tdata[49:2], m_tdata[81:50], m_tdata[113:82], m_tuser};
			if (breakout_q.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing expected", result_cnt));
			end else begin
				want = breakout_q.pop_front();
				if (got.sig != want.sig)
					report_mismatch($sformatf("result %0d signal %b, want %b",
						result_cnt, got.sig, want.sig));
				if (got.atr != want.atr)
					report_mismatch($sformatf("result %0d atr_out %h, want %h",
						result_cnt, got.atr, want.atr));
				if (got.chi != want.chi)
					report_mismatch($sformatf("result %0d chan_high %h, want %h",
						result_cnt, got.chi, want.chi));
				if (got.clo != want.clo)
					report_mismatch($sformatf("result %0d chan_low %h, want %h",
						result_cnt, got.clo, want.clo));
				if (got.rdy != want.rdy)
					report_mismatch($sformatf("result %0d ready_res %b, want %b",
						result_cnt, got.rdy, want.rdy));
			end
			result_cnt++;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_flat_warmup();
		test_edge_bars();
		test_window_extremes();
		test_cooldown_range();
		test_random_settings();
		drain_bars();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (breakout_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", breakout_q.size()));
		if (err_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dbatr_pkg.sv
rtl/dbatr_div.sv
rtl/dbatr_cell.sv
rtl/donchian_breakout_atr_core.sv
tb/tb_donchian_breakout_atr_core.sv
